@@ sv/wlt_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the link table.
`default_nettype none

package wlt_pkg;

   // Parameter defaults
   localparam int DEF_NUM_ROWS     = 64;
   localparam int DEF_NUM_SOURCES  = 64;
   localparam int DEF_ROW_CAPACITY = 16;

   // Fixed field widths
   localparam int KIND_W   = 1;
   localparam int INDEX_W  = 6;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 4;
   localparam int WEIGHT_W = 16;
   localparam int COUNT_W  = 5;
   localparam int TOTAL_W  = 16;
   localparam int SYS_W    = 24;
   localparam int ACTIVE_W = 7;

   localparam logic [ACTIVE_W-1:0] ACTIVE_ROWS_RESET = 7'd64;

   // Operation kinds
   localparam logic [KIND_W-1:0] KIND_ADD    = 1'b0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ROW_FULL  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_SATURATED = 3'd4;

   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;
   localparam logic [TOTAL_W-1:0]  TOTAL_MAX  = '1;
   localparam logic [SYS_W-1:0]    SYS_MAX    = '1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic clear_step;
      logic capture;
      logic read_tables;
      logic load_tables;
      logic search_step;
      logic read_last;
      logic commit;
   } ctrl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic clear_last;
      logic range_err;
      logic search_done;
      logic out_free;
   } dp_sts_type;

   // Address width of a store of the given depth, at least one bit
   function automatic int addr_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

`default_nettype wire

@@ sv/weighted_link_table_add_remove_core.sv @@
// Top level of the weighted link table: controller plus datapath.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_stall   kind, row_index, source_index
//   rsp      out        rsp_valid/rsp_stall   status, slot, link_weight, row_count,
//                                             row_total, source_total, system_total
//   csr      in         csr_write_enable      active_rows (write only)
//
// One item at a time: the next item can be accepted in the cycle after the commit of the
// last. An item walks the row's slots in the link RAM (one read per cycle) until a slot
// matches its source or the row ends. An item whose row or source index is out of range
// skips the walk and goes straight to the commit.
// After reset a clearing pass zeroes the row and source tables, one entry per cycle;
// req_stall is high then. A stalled result waits in the output register; the next item
// is accepted meanwhile and holds its commit until that register frees up.
`default_nettype none

module weighted_link_table_add_remove_core #(
   parameter int NUM_ROWS     = wlt_pkg::DEF_NUM_ROWS,
   parameter int NUM_SOURCES  = wlt_pkg::DEF_NUM_SOURCES,
   parameter int ROW_CAPACITY = wlt_pkg::DEF_ROW_CAPACITY
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [wlt_pkg::KIND_W-1:0]        req_kind,
   input  wire logic [wlt_pkg::INDEX_W-1:0]       req_row_index,
   input  wire logic [wlt_pkg::INDEX_W-1:0]       req_source_index,
   // Response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [wlt_pkg::STATUS_W-1:0]      rsp_status,
   output logic      [wlt_pkg::SLOT_W-1:0]        rsp_slot,
   output logic      [wlt_pkg::WEIGHT_W-1:0]      rsp_link_weight,
   output logic      [wlt_pkg::COUNT_W-1:0]       rsp_row_count,
   output logic      [wlt_pkg::TOTAL_W-1:0]       rsp_row_total,
   output logic      [wlt_pkg::TOTAL_W-1:0]       rsp_source_total,
   output logic      [wlt_pkg::SYS_W-1:0]         rsp_system_total,
   // Configuration: active row count
   input  wire logic                              csr_write_enable,
   input  wire logic [wlt_pkg::ACTIVE_W-1:0]      csr_write_data
);

   // Commands advance the datapath one step; status tells the controller when to move on
   wlt_pkg::ctrl_cmd_type cmd;
   wlt_pkg::dp_sts_type   sts;

   // Sequencer: clear pass, then accept, range check, table read, row search, last-entry
   // read and commit for each item in range; an item out of range goes from check to commit
   wlt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Stores, search compare, saturating add/remove arithmetic and result register
   wlt_dp #(
      .NUM_ROWS     (NUM_ROWS),
      .NUM_SOURCES  (NUM_SOURCES),
      .ROW_CAPACITY (ROW_CAPACITY)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_kind         (req_kind),
      .req_row_index    (req_row_index),
      .req_source_index (req_source_index),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_slot         (rsp_slot),
      .rsp_link_weight  (rsp_link_weight),
      .rsp_row_count    (rsp_row_count),
      .rsp_row_total    (rsp_row_total),
      .rsp_source_total (rsp_source_total),
      .rsp_system_total (rsp_system_total)
   );

endmodule

`default_nettype wire

@@ sv/wlt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module wlt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [wlt_pkg::addr_width(DEPTH)-1:0]      wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic                                       rd_en,
   input  wire logic [wlt_pkg::addr_width(DEPTH)-1:0]      rd_addr,
   output logic      [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/wlt_ctrl.sv @@
// Controller state machine: sequences clear, lookup, search and commit of one item.
`default_nettype none

module wlt_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire wlt_pkg::dp_sts_type   sts,
   output wlt_pkg::ctrl_cmd_type      cmd
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_CHECK  = 3'd2;
   localparam logic [2:0] S_TABLES = 3'd3;
   localparam logic [2:0] S_SEARCH = 3'd4;
   localparam logic [2:0] S_DECIDE = 3'd5;
   localparam logic [2:0] S_COMMIT = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.range_err) begin
               state_in = S_COMMIT;
            end else begin
               cmd.read_tables = 1'b1;
               state_in        = S_TABLES;
            end
         end
         S_TABLES: begin
            cmd.load_tables = 1'b1;
            state_in        = S_SEARCH;
         end
         S_SEARCH: begin
            cmd.search_step = 1'b1;
            if (sts.search_done) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.read_last = 1'b1;
            state_in      = S_COMMIT;
         end
         S_COMMIT: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

`default_nettype wire

@@ sv/wlt_dp.sv @@
// Datapath: link, row and source stores, search index, totals and result register.
`default_nettype none

module wlt_dp #(
   parameter int NUM_ROWS     = wlt_pkg::DEF_NUM_ROWS,
   parameter int NUM_SOURCES  = wlt_pkg::DEF_NUM_SOURCES,
   parameter int ROW_CAPACITY = wlt_pkg::DEF_ROW_CAPACITY
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire wlt_pkg::ctrl_cmd_type             cmd,
   output wlt_pkg::dp_sts_type                    sts,
   input  wire logic [wlt_pkg::KIND_W-1:0]        req_kind,
   input  wire logic [wlt_pkg::INDEX_W-1:0]       req_row_index,
   input  wire logic [wlt_pkg::INDEX_W-1:0]       req_source_index,
   input  wire logic                              csr_write_enable,
   input  wire logic [wlt_pkg::ACTIVE_W-1:0]      csr_write_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [wlt_pkg::STATUS_W-1:0]      rsp_status,
   output logic      [wlt_pkg::SLOT_W-1:0]        rsp_slot,
   output logic      [wlt_pkg::WEIGHT_W-1:0]      rsp_link_weight,
   output logic      [wlt_pkg::COUNT_W-1:0]       rsp_row_count,
   output logic      [wlt_pkg::TOTAL_W-1:0]       rsp_row_total,
   output logic      [wlt_pkg::TOTAL_W-1:0]       rsp_source_total,
   output logic      [wlt_pkg::SYS_W-1:0]         rsp_system_total
);

   localparam int RW        = wlt_pkg::addr_width(NUM_ROWS);
   localparam int SW        = wlt_pkg::addr_width(NUM_SOURCES);
   localparam int LINK_DEPTH = NUM_ROWS * ROW_CAPACITY;
   localparam int LW        = wlt_pkg::addr_width(LINK_DEPTH);
   localparam int IW        = wlt_pkg::addr_width(ROW_CAPACITY);
   localparam int CW        = $clog2(ROW_CAPACITY + 1);
   localparam int CLR_DEPTH = (NUM_ROWS > NUM_SOURCES) ? NUM_ROWS : NUM_SOURCES;
   localparam int CLW       = wlt_pkg::addr_width(CLR_DEPTH);
   localparam int WW        = wlt_pkg::WEIGHT_W;
   localparam int TW        = wlt_pkg::TOTAL_W;
   localparam int YW        = wlt_pkg::SYS_W;
   localparam int ROWW      = CW + TW;
   localparam int LINKW     = SW + WW;
   localparam logic [CW-1:0] CAP_CNT = CW'(ROW_CAPACITY);

   // Configuration and captured item
   logic [wlt_pkg::ACTIVE_W-1:0] active_ff, active_in;
   logic [wlt_pkg::KIND_W-1:0]   kind_ff, kind_in;
   logic [wlt_pkg::INDEX_W-1:0]  row_ff, row_in;
   logic [wlt_pkg::INDEX_W-1:0]  src_ff, src_in;

   // Working copy of the row and source entries, and the system total
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [TW-1:0] row_tot_ff, row_tot_in;
   logic [TW-1:0] src_tot_ff, src_tot_in;
   logic [YW-1:0] sys_tot_ff, sys_tot_in;

   // Search state
   logic [CW-1:0] idx_ff, idx_in;
   logic [IW-1:0] cmp_idx_ff, cmp_idx_in;
   logic          pend_ff, pend_in;
   logic          found_ff, found_in;
   logic [IW-1:0] slot_ff, slot_in;
   logic [WW-1:0] wt_ff, wt_in;

   logic [CLW-1:0] clr_ff, clr_in;

   // Result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [wlt_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [wlt_pkg::SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [WW-1:0]                  rsp_wt_ff, rsp_wt_in;
   logic [wlt_pkg::COUNT_W-1:0]    rsp_cnt_ff, rsp_cnt_in;
   logic [TW-1:0]                  rsp_row_tot_ff, rsp_row_tot_in;
   logic [TW-1:0]                  rsp_src_tot_ff, rsp_src_tot_in;
   logic [YW-1:0]                  rsp_sys_ff, rsp_sys_in;

   // Store ports
   logic [LINKW-1:0] link_rdata, link_wdata;
   logic [LW-1:0]    link_raddr, link_waddr, link_base;
   logic             link_re, link_we;
   logic [ROWW-1:0]  row_rdata, row_wdata;
   logic [RW-1:0]    row_waddr, row_addr;
   logic             row_we;
   logic [TW-1:0]    src_rdata, src_wdata;
   logic [SW-1:0]    src_waddr, src_addr;
   logic             src_we;

   logic [SW-1:0] link_src_rd;
   logic [WW-1:0] link_wt_rd;
   logic [CW-1:0] row_cnt_rd;
   logic [CW-1:0] last_idx;
   logic          hit, issue, totals_full, range_err;
   logic          clr_row_we, clr_src_we;

   // Outcome of the item
   logic [wlt_pkg::STATUS_W-1:0] res_status;
   logic [IW-1:0]                res_slot;
   logic [WW-1:0]                res_wt;
   logic [CW-1:0]                res_cnt;
   logic [TW-1:0]                res_row_tot, res_src_tot;
   logic [YW-1:0]                res_sys;
   logic                         res_link_we, bump_up, bump_down;
   logic [LW-1:0]                res_link_addr;
   logic [LINKW-1:0]             res_link_data;

   assign row_addr  = RW'(row_ff);
   assign src_addr  = SW'(src_ff);
   assign link_base = LW'(row_ff) * LW'(ROW_CAPACITY);

   assign link_src_rd = link_rdata[LINKW-1:WW];
   assign link_wt_rd  = link_rdata[WW-1:0];
   assign row_cnt_rd  = row_rdata[ROWW-1:TW];
   assign last_idx    = (cnt_ff == '0) ? '0 : cnt_ff - CW'(1);

   assign range_err = ({1'b0, row_ff} >= active_ff) ||
                      (int'(row_ff) >= NUM_ROWS) ||
                      (int'(src_ff) >= NUM_SOURCES);

   // Compare the slot read last cycle; issue the next slot unless it matched or the row is exhausted
   assign hit   = pend_ff && (link_src_rd == src_addr);
   assign issue = cmd.search_step && (idx_ff < cnt_ff) && !hit;

   assign totals_full = (row_tot_ff == wlt_pkg::TOTAL_MAX) ||
                        (src_tot_ff == wlt_pkg::TOTAL_MAX) ||
                        (sys_tot_ff == wlt_pkg::SYS_MAX);

   always_comb begin
      res_status    = wlt_pkg::ST_OK;
      res_slot      = slot_ff;
      res_wt        = wt_ff;
      res_cnt       = cnt_ff;
      res_row_tot   = row_tot_ff;
      res_src_tot   = src_tot_ff;
      res_sys       = sys_tot_ff;
      res_link_we   = 1'b0;
      res_link_addr = link_base + LW'(slot_ff);
      res_link_data = {src_addr, wt_ff};
      bump_up       = 1'b0;
      bump_down     = 1'b0;
      if (range_err) begin
         res_status  = wlt_pkg::ST_RANGE;
         res_slot    = '0;
         res_wt      = '0;
         res_cnt     = '0;
         res_row_tot = '0;
         res_src_tot = '0;
      end else if (kind_ff == wlt_pkg::KIND_ADD) begin
         if (found_ff) begin
            if ((wt_ff == wlt_pkg::WEIGHT_MAX) || totals_full) begin
               res_status = wlt_pkg::ST_SATURATED;
            end else begin
               res_wt        = wt_ff + WW'(1);
               res_link_we   = 1'b1;
               res_link_data = {src_addr, res_wt};
               bump_up       = 1'b1;
            end
         end else if (cnt_ff >= CAP_CNT) begin
            res_status = wlt_pkg::ST_ROW_FULL;
         end else if (totals_full) begin
            res_status = wlt_pkg::ST_SATURATED;
         end else begin
            // Append at the end of the row
            res_slot      = IW'(cnt_ff);
            res_wt        = WW'(1);
            res_cnt       = cnt_ff + CW'(1);
            res_link_we   = 1'b1;
            res_link_addr = link_base + LW'(cnt_ff);
            res_link_data = {src_addr, WW'(1)};
            bump_up       = 1'b1;
         end
      end else begin
         if (!found_ff) begin
            res_status = wlt_pkg::ST_NOT_FOUND;
         end else begin
            res_wt      = (wt_ff != '0) ? wt_ff - WW'(1) : '0;
            res_link_we = 1'b1;
            bump_down   = 1'b1;
            if (res_wt == '0) begin
               // Move the last link of the row into the freed slot
               res_link_data = link_rdata;
               res_cnt       = cnt_ff - CW'(1);
            end else begin
               res_link_data = {src_addr, res_wt};
            end
         end
      end
      if (bump_up) begin
         res_row_tot = row_tot_ff + TW'(1);
         res_src_tot = src_tot_ff + TW'(1);
         res_sys     = sys_tot_ff + YW'(1);
      end
      if (bump_down) begin
         res_row_tot = (row_tot_ff != '0) ? row_tot_ff - TW'(1) : '0;
         res_src_tot = (src_tot_ff != '0) ? src_tot_ff - TW'(1) : '0;
         res_sys     = (sys_tot_ff != '0) ? sys_tot_ff - YW'(1) : '0;
      end
   end

   // Store port selection
   assign clr_row_we = cmd.clear_step && (int'(clr_ff) < NUM_ROWS);
   assign clr_src_we = cmd.clear_step && (int'(clr_ff) < NUM_SOURCES);

   assign link_re    = issue || cmd.read_last;
   assign link_raddr = cmd.read_last ? link_base + LW'(last_idx) : link_base + LW'(idx_ff);
   assign link_we    = cmd.commit && res_link_we;
   assign link_waddr = res_link_addr;
   assign link_wdata = res_link_data;

   assign row_we    = clr_row_we || (cmd.commit && (bump_up || bump_down));
   assign row_waddr = cmd.clear_step ? RW'(clr_ff) : row_addr;
   assign row_wdata = cmd.clear_step ? '0 : {res_cnt, res_row_tot};

   assign src_we    = clr_src_we || (cmd.commit && (bump_up || bump_down));
   assign src_waddr = cmd.clear_step ? SW'(clr_ff) : src_addr;
   assign src_wdata = cmd.clear_step ? '0 : res_src_tot;

   wlt_ram #(.WIDTH(LINKW), .DEPTH(LINK_DEPTH)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_en   (link_re),
      .rd_addr (link_raddr),
      .rd_data (link_rdata)
   );

   wlt_ram #(.WIDTH(ROWW), .DEPTH(NUM_ROWS)) u_row_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (row_waddr),
      .wr_data (row_wdata),
      .rd_en   (cmd.read_tables),
      .rd_addr (row_addr),
      .rd_data (row_rdata)
   );

   wlt_ram #(.WIDTH(TW), .DEPTH(NUM_SOURCES)) u_src_ram (
      .clock   (clock),
      .wr_en   (src_we),
      .wr_addr (src_waddr),
      .wr_data (src_wdata),
      .rd_en   (cmd.read_tables),
      .rd_addr (src_addr),
      .rd_data (src_rdata)
   );

   // Next-state logic
   always_comb begin
      active_in      = csr_write_enable ? csr_write_data : active_ff;
      kind_in        = kind_ff;
      row_in         = row_ff;
      src_in         = src_ff;
      cnt_in         = cnt_ff;
      row_tot_in     = row_tot_ff;
      src_tot_in     = src_tot_ff;
      sys_tot_in     = sys_tot_ff;
      idx_in         = idx_ff;
      cmp_idx_in     = cmp_idx_ff;
      pend_in        = pend_ff;
      found_in       = found_ff;
      slot_in        = slot_ff;
      wt_in          = wt_ff;
      clr_in         = clr_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_wt_in      = rsp_wt_ff;
      rsp_cnt_in     = rsp_cnt_ff;
      rsp_row_tot_in = rsp_row_tot_ff;
      rsp_src_tot_in = rsp_src_tot_ff;
      rsp_sys_in     = rsp_sys_ff;

      if (cmd.clear_step) begin
         clr_in = clr_ff + CLW'(1);
      end
      if (cmd.capture) begin
         kind_in = req_kind;
         row_in  = req_row_index;
         src_in  = req_source_index;
      end
      if (cmd.load_tables) begin
         cnt_in     = (row_cnt_rd > CAP_CNT) ? CAP_CNT : row_cnt_rd;
         row_tot_in = row_rdata[TW-1:0];
         src_tot_in = src_rdata;
         idx_in     = '0;
         pend_in    = 1'b0;
         found_in   = 1'b0;
         slot_in    = '0;
         wt_in      = '0;
      end
      if (cmd.search_step) begin
         pend_in = issue;
         if (issue) begin
            idx_in     = idx_ff + CW'(1);
            cmp_idx_in = IW'(idx_ff);
         end
         if (hit) begin
            found_in = 1'b1;
            slot_in  = cmp_idx_ff;
            wt_in    = link_wt_rd;
         end
      end
      if (cmd.commit) begin
         sys_tot_in     = res_sys;
         rsp_valid_in   = 1'b1;
         rsp_status_in  = res_status;
         rsp_slot_in    = wlt_pkg::SLOT_W'(res_slot);
         rsp_wt_in      = res_wt;
         rsp_cnt_in     = wlt_pkg::COUNT_W'(res_cnt);
         rsp_row_tot_in = res_row_tot;
         rsp_src_tot_in = res_src_tot;
         rsp_sys_in     = res_sys;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= wlt_pkg::ACTIVE_ROWS_RESET;
         sys_tot_ff   <= '0;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         sys_tot_ff   <= sys_tot_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      row_ff         <= row_in;
      src_ff         <= src_in;
      cnt_ff         <= cnt_in;
      row_tot_ff     <= row_tot_in;
      src_tot_ff     <= src_tot_in;
      idx_ff         <= idx_in;
      cmp_idx_ff     <= cmp_idx_in;
      found_ff       <= found_in;
      slot_ff        <= slot_in;
      wt_ff          <= wt_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_wt_ff      <= rsp_wt_in;
      rsp_cnt_ff     <= rsp_cnt_in;
      rsp_row_tot_ff <= rsp_row_tot_in;
      rsp_src_tot_ff <= rsp_src_tot_in;
      rsp_sys_ff     <= rsp_sys_in;
   end

   assign sts.clear_last  = (int'(clr_ff) == CLR_DEPTH - 1);
   assign sts.range_err   = range_err;
   assign sts.search_done = hit || (idx_ff >= cnt_ff);
   assign sts.out_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_link_weight  = rsp_wt_ff;
   assign rsp_row_count    = rsp_cnt_ff;
   assign rsp_row_total    = rsp_row_tot_ff;
   assign rsp_source_total = rsp_src_tot_ff;
   assign rsp_system_total = rsp_sys_ff;

endmodule

`default_nettype wire
